### rtl/sip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types, codes and default sizes of the string intern pool.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int POOL_BYTES_DEF = 4096;
    localparam int MAX_STRING_DEF = 255;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 12;
    localparam int KIND_W  = 2;
    localparam int ELEN_W  = 8;
    localparam int CLEN_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE  = 2'd0,
        OP_EMPTY = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INTERNED = 2'd0,
        KIND_LENGTH   = 2'd1,
        KIND_FULL     = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_INTERN   = 2'd0,
        CMD_QUERY    = 2'd1,
        CMD_TOO_LONG = 2'd2
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t          code;
        logic [CLEN_W-1:0]  len;
        logic [OFF_W-1:0]   qoff;
    } cmd_t;

endpackage
`default_nettype wire

### rtl/sip_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_req_if / sip_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface sip_req_if;
    import sip_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [OFF_W-1:0]  query_offset;

    modport source (output valid, output op, output data_byte, output last,
                    output query_offset, input ready);
    modport sink   (input valid, input op, input data_byte, input last,
                    input query_offset, output ready);
endinterface

interface sip_rsp_if;
    import sip_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  entry_offset;
    logic              found_existing;
    logic [ELEN_W-1:0] entry_length;

    modport source (output valid, output kind, output entry_offset,
                    output found_existing, output entry_length, input ready);
    modport sink   (input valid, input kind, input entry_offset,
                    input found_existing, input entry_length, output ready);
endinterface
`default_nettype wire

### rtl/sip_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/sip_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_front
// Accepts request items, stages string bytes and issues commands.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int MAX_STRING = sip_pkg::MAX_STRING_DEF,
    localparam int LEN_W = $clog2(MAX_STRING + 1),
    localparam int SAW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sip_req_if.sink              req,
    output logic                 push,
    output sip_pkg::cmd_t        push_cmd,
    input  logic                 q_full,
    input  logic                 stage_release,
    output logic                 stage_we,
    output logic [SAW-1:0]       stage_waddr,
    output logic [7:0]           stage_wdata
);
    import sip_pkg::*;

    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             long_reg, long_next;
    logic             busy_reg, busy_next;
    logic             acc;
    logic             room;

    // staging is held while the back end still reads it
    assign req.ready   = !busy_reg && !q_full;
    assign acc         = req.valid && req.ready;
    assign room        = cnt_reg < LEN_W'(MAX_STRING);
    assign stage_waddr = SAW'(cnt_reg);
    assign stage_wdata = req.data_byte;

    always_comb
    begin
        cnt_next      = cnt_reg;
        long_next     = long_reg;
        busy_next     = busy_reg;
        stage_we      = 1'b0;
        push          = 1'b0;
        push_cmd.code = CMD_QUERY;
        push_cmd.len  = '0;
        push_cmd.qoff = req.query_offset;
        if (stage_release)
        begin
            busy_next = 1'b0;
        end
        if (acc)
        begin
            unique case (op_t'(req.op))
                OP_BYTE:
                begin
                    stage_we = room;
                    if (room)
                    begin
                        cnt_next = cnt_reg + LEN_W'(1);
                    end
                    else
                    begin
                        long_next = 1'b1;
                    end
                    if (req.last)
                    begin
                        push = 1'b1;
                        if (long_next)
                        begin
                            push_cmd.code = CMD_TOO_LONG;
                        end
                        else
                        begin
                            push_cmd.code = CMD_INTERN;
                            push_cmd.len  = CLEN_W'(cnt_next);
                            busy_next     = 1'b1;
                        end
                        cnt_next  = '0;
                        long_next = 1'b0;
                    end
                end
                OP_EMPTY:
                begin
                    push          = 1'b1;
                    push_cmd.code = CMD_INTERN;
                    cnt_next      = '0;
                    long_next     = 1'b0;
                end
                OP_QUERY:
                begin
                    push = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            long_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            long_reg <= long_next;
            busy_reg <= busy_next;
        end
    end
endmodule
`default_nettype wire

### rtl/sip_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_cmd_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sip_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sip_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          q_valid,
    output sip_pkg::cmd_t q_cmd,
    input  logic          pop
);
    import sip_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

### rtl/sip_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_back
// Walks the pool for a staged string, appends on a miss, answers queries and reports over-long strings.
// ----------------------------------------------------------------------------
module sip_back #(
    parameter int POOL_BYTES = sip_pkg::POOL_BYTES_DEF,
    parameter int MAX_STRING = sip_pkg::MAX_STRING_DEF,
    localparam int AW = $clog2(POOL_BYTES),
    localparam int OW = AW + 1,
    localparam int LEN_W = $clog2(MAX_STRING + 1),
    localparam int SAW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sip_pkg::cmd_t   q_cmd,
    output logic            q_pop,
    output logic            stage_release,
    output logic [SAW-1:0]  stage_raddr,
    input  logic [7:0]      stage_rdata,
    output logic            pool_we,
    output logic [AW-1:0]   pool_waddr,
    output logic [7:0]      pool_wdata,
    output logic [AW-1:0]   pool_raddr,
    input  logic [7:0]      pool_rdata,
    sip_rsp_if.source       rsp
);
    import sip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QDAT, S_WALK, S_H0, S_H1, S_H2, S_CI, S_CC,
        S_FIT, S_HDR, S_CPR, S_CPW, S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [OW-1:0]     used_reg, used_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [1:0]        hk_reg, hk_next;
    logic [7:0]        lo_reg, lo_next;
    logic [CLEN_W-1:0] elen_reg, elen_next;
    kind_t             rkind_reg, rkind_next;
    logic [OFF_W-1:0]  roff_reg, roff_next;
    logic              rfound_reg, rfound_next;
    logic [ELEN_W-1:0] rlen_reg, rlen_next;
    logic              ovld_reg, ovld_next;
    kind_t             okind_reg, okind_next;
    logic [OFF_W-1:0]  ooff_reg, ooff_next;
    logic              ofound_reg, ofound_next;
    logic [ELEN_W-1:0] olen_reg, olen_next;

    logic [LEN_W-1:0]  n;
    logic [CLEN_W-1:0] elen_now;
    logic [31:0]       need;
    logic [AW-1:0]     body_addr;
    logic              last_k;
    logic              q_in_range;
    logic              out_free;

    assign n          = LEN_W'(cmd_reg.len);
    assign elen_now   = {pool_rdata, lo_reg};
    assign need       = 32'(used_reg) + 32'd4 + 32'(n);
    assign body_addr  = AW'(32'(off_reg) + 32'd4 + 32'(k_reg));
    assign last_k     = k_reg == LEN_W'(32'(n) - 32'd1);
    assign q_in_range = 32'(cmd_reg.qoff) < POOL_BYTES;
    assign out_free   = !ovld_reg || rsp.ready;

    assign rsp.valid          = ovld_reg;
    assign rsp.kind           = okind_reg;
    assign rsp.entry_offset   = ooff_reg;
    assign rsp.found_existing = ofound_reg;
    assign rsp.entry_length   = olen_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        off_next      = off_reg;
        used_next     = used_reg;
        k_next        = k_reg;
        hk_next       = hk_reg;
        lo_next       = lo_reg;
        elen_next     = elen_reg;
        rkind_next    = rkind_reg;
        roff_next     = roff_reg;
        rfound_next   = rfound_reg;
        rlen_next     = rlen_reg;
        ovld_next     = ovld_reg && !rsp.ready;
        okind_next    = okind_reg;
        ooff_next     = ooff_reg;
        ofound_next   = ofound_reg;
        olen_next     = olen_reg;
        q_pop         = 1'b0;
        stage_release = 1'b0;
        stage_raddr   = SAW'(k_reg);
        pool_we       = 1'b0;
        pool_waddr    = AW'(32'(off_reg) + 32'(hk_reg));
        pool_wdata    = 8'd0;
        pool_raddr    = AW'(off_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.code)
                        CMD_QUERY:
                        begin
                            state_next = S_QRD;
                        end
                        CMD_INTERN:
                        begin
                            off_next   = '0;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            rkind_next  = KIND_TOO_LONG;
                            roff_next   = '0;
                            rfound_next = 1'b0;
                            rlen_next   = '0;
                            state_next  = S_EMIT;
                        end
                    endcase
                end
            end
            S_QRD:
            begin
                pool_raddr = AW'(cmd_reg.qoff);
                state_next = S_QDAT;
            end
            S_QDAT:
            begin
                rkind_next  = KIND_LENGTH;
                roff_next   = cmd_reg.qoff;
                rfound_next = 1'b0;
                rlen_next   = q_in_range ? pool_rdata : '0;
                state_next  = S_EMIT;
            end
            S_WALK:
            begin
                state_next = (off_reg < used_reg) ? S_H0 : S_FIT;
            end
            S_H0:
            begin
                state_next = S_H1;
            end
            S_H1:
            begin
                pool_raddr = AW'(32'(off_reg) + 32'd1);
                lo_next    = pool_rdata;
                state_next = S_H2;
            end
            S_H2:
            begin
                elen_next = elen_now;
                if (elen_now == CLEN_W'(n))
                begin
                    if (n == '0)
                    begin
                        rkind_next  = KIND_INTERNED;
                        roff_next   = OFF_W'(off_reg);
                        rfound_next = 1'b1;
                        rlen_next   = '0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_CI;
                    end
                end
                else
                begin
                    off_next   = OW'(32'(off_reg) + 32'(elen_now) + 32'd4);
                    state_next = S_WALK;
                end
            end
            S_CI:
            begin
                pool_raddr = body_addr;
                state_next = S_CC;
            end
            S_CC:
            begin
                if (pool_rdata != stage_rdata)
                begin
                    off_next   = OW'(32'(off_reg) + 32'(elen_reg) + 32'd4);
                    state_next = S_WALK;
                end
                else if (last_k)
                begin
                    rkind_next  = KIND_INTERNED;
                    roff_next   = OFF_W'(off_reg);
                    rfound_next = 1'b1;
                    rlen_next   = ELEN_W'(n);
                    state_next  = S_EMIT;
                end
                else
                begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = S_CI;
                end
            end
            S_FIT:
            begin
                if (need > 32'(POOL_BYTES))
                begin
                    rkind_next  = KIND_FULL;
                    roff_next   = '0;
                    rfound_next = 1'b0;
                    rlen_next   = ELEN_W'(n);
                    state_next  = S_EMIT;
                end
                else
                begin
                    off_next   = used_reg;
                    hk_next    = '0;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                // little-endian length header, upper two bytes always zero
                pool_we = 1'b1;
                unique case (hk_reg)
                    2'd0:    pool_wdata = 8'(CLEN_W'(n));
                    2'd1:    pool_wdata = 8'(CLEN_W'(n) >> 8);
                    default: pool_wdata = 8'd0;
                endcase
                hk_next = hk_reg + 2'd1;
                if (hk_reg == 2'd3)
                begin
                    k_next = '0;
                    if (n == '0)
                    begin
                        used_next   = OW'(need);
                        rkind_next  = KIND_INTERNED;
                        roff_next   = OFF_W'(off_reg);
                        rfound_next = 1'b0;
                        rlen_next   = '0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_CPR;
                    end
                end
            end
            S_CPR:
            begin
                state_next = S_CPW;
            end
            S_CPW:
            begin
                pool_we    = 1'b1;
                pool_waddr = body_addr;
                pool_wdata = stage_rdata;
                if (last_k)
                begin
                    used_next   = OW'(need);
                    rkind_next  = KIND_INTERNED;
                    roff_next   = OFF_W'(off_reg);
                    rfound_next = 1'b0;
                    rlen_next   = ELEN_W'(n);
                    state_next  = S_EMIT;
                end
                else
                begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = S_CPR;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovld_next     = 1'b1;
                    okind_next    = rkind_reg;
                    ooff_next     = roff_reg;
                    ofound_next   = rfound_reg;
                    olen_next     = rlen_reg;
                    // only a non-empty interned string holds the staging buffer
                    stage_release = cmd_reg.code == CMD_INTERN && n != '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        off_reg    <= off_next;
        k_reg      <= k_next;
        hk_reg     <= hk_next;
        lo_reg     <= lo_next;
        elen_reg   <= elen_next;
        rkind_reg  <= rkind_next;
        roff_reg   <= roff_next;
        rfound_reg <= rfound_next;
        rlen_reg   <= rlen_next;
        okind_reg  <= okind_next;
        ooff_reg   <= ooff_next;
        ofound_reg <= ofound_next;
        olen_reg   <= olen_next;
    end
endmodule
`default_nettype wire

### rtl/string_intern_pool.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_intern_pool
// Byte-string interning pool with a packed length-prefixed store.
// ----------------------------------------------------------------------------
// A string arrives one byte per item, and each byte that fits is written to
// the staging RAM. The last byte of a string that fits starts a walk of the
// pool: each entry header is read and its length compared, an entry of equal
// length is compared byte by byte, and on a miss the header and bytes are
// appended, all through the single read and write port of the pool RAM.
// While that walk runs every new item waits at the input; all commands,
// queries, empty strings and over-long strings included, reach the back end
// through a two-entry command queue. No clearing pass is needed after reset.
module string_intern_pool #(
    parameter int POOL_BYTES = sip_pkg::POOL_BYTES_DEF,
    parameter int MAX_STRING = sip_pkg::MAX_STRING_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    sip_req_if.sink    req,
    sip_rsp_if.source  rsp
);
    import sip_pkg::*;

    localparam int AW  = $clog2(POOL_BYTES);
    localparam int SAW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;

    logic           push;
    cmd_t           push_cmd;
    logic           q_full;
    logic           q_valid;
    cmd_t           q_cmd;
    logic           q_pop;
    logic           stage_release;
    logic           stage_we;
    logic [SAW-1:0] stage_waddr;
    logic [7:0]     stage_wdata;
    logic [SAW-1:0] stage_raddr;
    logic [7:0]     stage_rdata;
    logic           pool_we;
    logic [AW-1:0]  pool_waddr;
    logic [7:0]     pool_wdata;
    logic [AW-1:0]  pool_raddr;
    logic [7:0]     pool_rdata;

    sip_front #(.MAX_STRING(MAX_STRING)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full),
        .stage_release (stage_release),
        .stage_we      (stage_we),
        .stage_waddr   (stage_waddr),
        .stage_wdata   (stage_wdata)
    );

    sip_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    sip_ram #(.WIDTH(8), .DEPTH(MAX_STRING)) u_stage_ram (
        .clk   (clk),
        .we    (stage_we),
        .waddr (stage_waddr),
        .wdata (stage_wdata),
        .raddr (stage_raddr),
        .rdata (stage_rdata)
    );

    sip_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    sip_back #(.POOL_BYTES(POOL_BYTES), .MAX_STRING(MAX_STRING)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .stage_release (stage_release),
        .stage_raddr   (stage_raddr),
        .stage_rdata   (stage_rdata),
        .pool_we       (pool_we),
        .pool_waddr    (pool_waddr),
        .pool_wdata    (pool_wdata),
        .pool_raddr    (pool_raddr),
        .pool_rdata    (pool_rdata),
        .rsp           (rsp)
    );
endmodule
`default_nettype wire

### rtl/sip_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks on result items of the string intern pool.
// ----------------------------------------------------------------------------
module sip_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      rsp_valid,
    input wire                      rsp_ready,
    input wire [sip_pkg::KIND_W-1:0] rsp_kind,
    input wire [sip_pkg::OFF_W-1:0]  rsp_offset,
    input wire                      rsp_found,
    input wire [sip_pkg::ELEN_W-1:0] rsp_length
);
    import sip_pkg::*;

    // a stalled result item keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
        $stable(rsp_offset) && $stable(rsp_found) && $stable(rsp_length))
        else $error("result item changed while stalled");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_kind == KIND_INTERNED)
        else $error("found flag on a non-intern result");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_FULL |-> rsp_offset == '0 && !rsp_found)
        else $error("pool full result carries an offset");

    a_long: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_TOO_LONG |->
        rsp_offset == '0 && !rsp_found && rsp_length == '0)
        else $error("too long result carries payload");
endmodule

bind string_intern_pool sip_checker u_sip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_kind   (rsp.kind),
    .rsp_offset (rsp.entry_offset),
    .rsp_found  (rsp.found_existing),
    .rsp_length (rsp.entry_length)
);
`default_nettype wire
